@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Every check is clocked on clk and
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define AGC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that forces a consequence in the next cycle.
`define AGC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ hw/rtl/agc_pkg.sv @@
// ----------------------------------------------------------------------------
// agc_pkg
// Shared constants, codes and arithmetic helpers of the ducking gain
// controller.
// ----------------------------------------------------------------------------
package agc_pkg;

    localparam int GainW    = 17;
    localparam int NumPots  = 7;
    localparam int PosW     = 8;
    localparam int LenW     = 9;

    localparam logic [GainW-1:0] One       = 17'd65536;
    localparam logic [GainW-1:0] Half      = 17'd32768;
    localparam logic [GainW-1:0] FloorMin  = 17'd3277;
    localparam logic [GainW-1:0] FloorSpan = 17'd62259;
    localparam logic [LenW-1:0]  MaxTracks = 9'd256;

    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_MUSIC  = 2'd1;
    localparam logic [1:0] MODE_TABATA = 2'd2;
    localparam logic [1:0] MODE_CHILL  = 2'd3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DOWN = 2'd1;
    localparam logic [1:0] PH_HELD = 2'd2;
    localparam logic [1:0] PH_UP   = 2'd3;

    localparam logic [1:0] CFG_STEP_SLOW = 2'd0;
    localparam logic [1:0] CFG_STEP_FAST = 2'd1;
    localparam logic [1:0] CFG_PL_LEN    = 2'd2;

    // Floor of n / 10 by reciprocal multiplication, exact for n below 2^18.
    function automatic logic [GainW-1:0] div10(input logic [GainW-1:0] n);
        logic [37:0] p;
        p = {21'd0, n} * 38'd104858;
        return p[36:20];
    endfunction

endpackage

@@ hw/rtl/audio_ducking_gain_controller.sv @@
// ----------------------------------------------------------------------------
// audio_ducking_gain_controller
// Control-rate gain controller: knob smoothing, pause and ducking fades,
// override modes, crossfade, playlist position and four channel gains.
// ----------------------------------------------------------------------------
// Usage: one input beat on s_axis carries all knob, switch and button levels
// of a tick; one output beat on m_axis carries the resulting gains and status.
// The cfg port writes the crossfade steps and the playlist length; the user
// must write them only while idle, which the block itself does not enforce.
// Each beat is taken while idle; then the seven smoothing lanes update and the
// controls settle together, and a single shared rounding multiplier forms the
// floor and the six channel products one after another. A track end that
// advances the position adds a wrap step that subtracts the length repeatedly.
// s_axis_tready is high only while the sequencer is idle, so one tick is in
// flight at a time. A finished result waits in the output register; the next
// beat is accepted meanwhile and its result holds in the last step until
// m_axis is free. Reset sets the control state but not the captured input
// beat; the duck and pause gains start at one, the crossfade gain and the
// levels at zero, and all modes at none.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_ducking_gain_controller
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // laptop_pot, bluetooth_pot, duck_speed_pot, duck_level_pot, soundboard_pot,
    // pause_level_pot, playlist_pot, source_switch, soundbyte_active,
    // track_complete, button_levels, zero pad
    input  logic [127:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // laptop_volume, bluetooth_volume, playlist_volume, soundboard_volume,
    // current_source, override_mode, saved_override, playlist_index,
    // track_trigger, duck_phase, zero pad
    output logic [87:0]  m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [16:0]  cfg_data
);

    localparam int GW = agc_pkg::GainW;

    typedef enum logic [3:0] {
        S_IDLE, S_CTRL, S_MOD, S_PREP, S_UPD,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_OUT
    } state_t;

    state_t state_reg;

    logic [GW-1:0] step_slow_reg, step_fast_reg;
    logic [agc_pkg::LenW-1:0] pl_len_reg;

    logic [GW-1:0] pot_reg [agc_pkg::NumPots];
    logic [1:0]    src_in_reg;
    logic          playing_reg;
    logic          tc_reg;
    logic [3:0]    btn_reg;

    logic [GW-1:0] level [agc_pkg::NumPots];

    logic [1:0]    duck_ph_reg;
    logic [GW-1:0] duck_gain_reg, pause_gain_reg, cf_gain_reg;
    logic          pause_act_reg;
    logic [3:0]    btn_hist_reg;
    logic [1:0]    mode_reg, saved_reg, source_reg;
    logic [agc_pkg::PosW-1:0] pos_reg;
    logic [agc_pkg::LenW-1:0] rem_reg;
    logic          trig_reg;
    logic [GW-1:0] step_reg, floor_reg;
    logic [GW-1:0] t0_reg, t1_reg, t2_reg, o0_reg, o1_reg, o2_reg;

    logic          out_valid_reg;
    logic [87:0]   out_data_reg;

    logic [GW-1:0] mul_a, mul_b, mul_y;
    logic          out_free;

    // Control update for one tick.
    logic [3:0]    rise;
    logic [1:0]    mode_c, saved_c, src_c, next_m;
    logic [agc_pkg::LenW-1:0] len_c;
    logic          adv_c;
    logic [GW-1:0] cf_step, cf_c;
    logic [GW:0]   cf_sum;

    // Slews.
    logic [GW-1:0] p_target, pg_c, dg_c, bg, sf;
    logic [1:0]    ph_c;
    logic [GW:0]   fs_sum, du_sum;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;

    genvar g;
    generate
        for (g = 0; g < agc_pkg::NumPots; g++)
        begin : g_lane
            agc_lane u_lane
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .en     (state_reg == S_CTRL),
                .sample (pot_reg[g]),
                .level  (level[g])
            );
        end
    endgenerate

    always_comb
    begin
        rise    = btn_reg & ~btn_hist_reg;
        mode_c  = mode_reg;
        saved_c = saved_reg;
        next_m  = agc_pkg::MODE_NONE;
        len_c   = (pl_len_reg > agc_pkg::MaxTracks) ? agc_pkg::MaxTracks : pl_len_reg;
        adv_c   = 1'b0;
        if (tc_reg)
        begin
            if (mode_reg == agc_pkg::MODE_TABATA)
                mode_c = saved_reg;
            else if (len_c != '0)
                adv_c = 1'b1;
        end
        for (int b = 1; b <= 3; b++)
        begin
            if (rise[b])
            begin
                next_m = (mode_c == 2'(b)) ? agc_pkg::MODE_NONE : 2'(b);
                if (next_m == agc_pkg::MODE_TABATA)
                    saved_c = mode_c;
                mode_c = next_m;
            end
        end
        src_c = (src_in_reg == 2'd3) ? 2'd0 : src_in_reg;
        if (src_c != source_reg && source_reg != 2'd0 && mode_c != agc_pkg::MODE_NONE)
            mode_c = agc_pkg::MODE_NONE;
        cf_step = (mode_c == agc_pkg::MODE_CHILL) ? step_slow_reg : step_fast_reg;
        cf_sum  = {1'b0, cf_gain_reg} + {1'b0, cf_step};
        if (mode_c != agc_pkg::MODE_NONE)
            cf_c = (cf_sum > {1'b0, agc_pkg::One}) ? agc_pkg::One : cf_sum[GW-1:0];
        else
            cf_c = (cf_gain_reg > cf_step) ? cf_gain_reg - cf_step : '0;
    end

    always_comb
    begin
        p_target = pause_act_reg ? level[5] : agc_pkg::One;
        pg_c     = pause_gain_reg;
        if (pause_gain_reg > p_target)
            pg_c = (pause_gain_reg - p_target > step_reg) ? pause_gain_reg - step_reg : p_target;
        else if (pause_gain_reg < p_target)
            pg_c = (p_target - pause_gain_reg > step_reg) ? pause_gain_reg + step_reg : p_target;

        dg_c   = duck_gain_reg;
        ph_c   = duck_ph_reg;
        fs_sum = {1'b0, floor_reg} + {1'b0, step_reg};
        du_sum = {1'b0, duck_gain_reg} + {1'b0, step_reg};
        unique case (duck_ph_reg)
            agc_pkg::PH_IDLE:
            begin
                if (playing_reg)
                    ph_c = agc_pkg::PH_DOWN;
            end
            agc_pkg::PH_DOWN:
            begin
                if ({1'b0, duck_gain_reg} <= fs_sum)
                begin
                    dg_c = floor_reg;
                    ph_c = agc_pkg::PH_HELD;
                end
                else
                    dg_c = duck_gain_reg - step_reg;
            end
            agc_pkg::PH_HELD:
            begin
                dg_c = floor_reg;
                if (!playing_reg)
                    ph_c = agc_pkg::PH_UP;
            end
            default:
            begin
                if (playing_reg)
                    ph_c = agc_pkg::PH_DOWN;
                else if (du_sum >= {1'b0, agc_pkg::One})
                begin
                    dg_c = agc_pkg::One;
                    ph_c = agc_pkg::PH_IDLE;
                end
                else
                    dg_c = du_sum[GW-1:0];
            end
        endcase
    end

    assign bg = pause_act_reg ? pause_gain_reg : duck_gain_reg;
    assign sf = agc_pkg::One - cf_gain_reg;

    always_comb
    begin
        mul_a = level[0];
        mul_b = bg;
        case (state_reg)
            S_PREP:  begin mul_a = agc_pkg::FloorSpan; mul_b = level[3];      end
            S_M1:    begin mul_a = level[1];           mul_b = bg;            end
            S_M2:    begin mul_a = level[6];           mul_b = cf_gain_reg;   end
            S_M3:    begin mul_a = t0_reg;             mul_b = sf;            end
            S_M4:    begin mul_a = t1_reg;             mul_b = sf;            end
            S_M5:    begin mul_a = t2_reg;             mul_b = duck_gain_reg; end
            default: begin mul_a = level[0];           mul_b = bg;            end
        endcase
    end

    agc_gain_mul u_mul
    (
        .a (mul_a),
        .b (mul_b),
        .y (mul_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_slow_reg <= 17'd66;
            step_fast_reg <= 17'd655;
            pl_len_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                agc_pkg::CFG_STEP_SLOW: step_slow_reg <= cfg_data;
                agc_pkg::CFG_STEP_FAST: step_fast_reg <= cfg_data;
                agc_pkg::CFG_PL_LEN:    pl_len_reg    <= cfg_data[agc_pkg::LenW-1:0];
                default: ;
            endcase
        end
    end

    // Input beat capture; pots above one are taken as one.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            for (int i = 0; i < agc_pkg::NumPots; i++)
                pot_reg[i] <= (s_axis_tdata[i*GW +: GW] > agc_pkg::One) ? agc_pkg::One
                                                                       : s_axis_tdata[i*GW +: GW];
            src_in_reg  <= s_axis_tdata[120:119];
            playing_reg <= s_axis_tdata[121];
            tc_reg      <= s_axis_tdata[122];
            btn_reg     <= s_axis_tdata[126:123];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            duck_ph_reg    <= agc_pkg::PH_IDLE;
            duck_gain_reg  <= agc_pkg::One;
            pause_gain_reg <= agc_pkg::One;
            cf_gain_reg    <= '0;
            pause_act_reg  <= 1'b0;
            btn_hist_reg   <= '0;
            mode_reg       <= agc_pkg::MODE_NONE;
            saved_reg      <= agc_pkg::MODE_NONE;
            source_reg     <= 2'd0;
            pos_reg        <= '0;
            rem_reg        <= '0;
            trig_reg       <= 1'b0;
            step_reg       <= '0;
            floor_reg      <= '0;
            t0_reg         <= '0;
            t1_reg         <= '0;
            t2_reg         <= '0;
            o0_reg         <= '0;
            o1_reg         <= '0;
            o2_reg         <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            // The output step below reloads the register itself when it fires.
            if (out_valid_reg && m_axis_tready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                        state_reg <= S_CTRL;
                end
                S_CTRL:
                begin
                    btn_hist_reg  <= btn_reg;
                    pause_act_reg <= pause_act_reg ^ rise[0];
                    mode_reg      <= mode_c;
                    saved_reg     <= saved_c;
                    source_reg    <= src_c;
                    cf_gain_reg   <= cf_c;
                    trig_reg      <= adv_c;
                    rem_reg       <= {1'b0, pos_reg} + 9'd1;
                    state_reg     <= adv_c ? S_MOD : S_PREP;
                end
                S_MOD:
                begin
                    // Wrap by repeated subtraction of the playlist length.
                    if (rem_reg >= len_c)
                        rem_reg <= rem_reg - len_c;
                    else
                    begin
                        pos_reg   <= rem_reg[agc_pkg::PosW-1:0];
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    step_reg  <= agc_pkg::div10(level[2] + 17'd5);
                    floor_reg <= agc_pkg::FloorMin + mul_y;
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    pause_gain_reg <= pg_c;
                    duck_gain_reg  <= dg_c;
                    duck_ph_reg    <= ph_c;
                    state_reg      <= S_M0;
                end
                S_M0: begin t0_reg <= mul_y; state_reg <= S_M1; end
                S_M1: begin t1_reg <= mul_y; state_reg <= S_M2; end
                S_M2: begin t2_reg <= mul_y; state_reg <= S_M3; end
                S_M3: begin o0_reg <= mul_y; state_reg <= S_M4; end
                S_M4: begin o1_reg <= mul_y; state_reg <= S_M5; end
                S_M5: begin o2_reg <= mul_y; state_reg <= S_OUT; end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'd0, duck_ph_reg, trig_reg, pos_reg,
                                          saved_reg, mode_reg, source_reg,
                                          playing_reg ? level[4] : 17'd0,
                                          o2_reg,
                                          (source_reg == 2'd2) ? o1_reg : 17'd0,
                                          (source_reg == 2'd1) ? o0_reg : 17'd0};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `AGC_ASSERT(a_cf_bound, cf_gain_reg <= agc_pkg::One, "crossfade gain above one")
    `AGC_ASSERT(a_gain_bound, duck_gain_reg <= agc_pkg::One && pause_gain_reg <= agc_pkg::One, "duck or pause gain above one")
    `AGC_ASSERT_NEXT(a_idle_mode, state_reg == S_IDLE, $stable(mode_reg) && $stable(pos_reg), "control state changed while idle")

endmodule

@@ hw/rtl/agc_lane.sv @@
// ----------------------------------------------------------------------------
// agc_lane
// One smoothing lane: moves its level a tenth of the way toward the sample,
// rounded away from the level so that the sample is reached exactly.
// ----------------------------------------------------------------------------
module agc_lane
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [agc_pkg::GainW-1:0]  sample,
    output logic [agc_pkg::GainW-1:0]  level
);

    logic [agc_pkg::GainW-1:0] level_reg;
    logic [agc_pkg::GainW-1:0] level_next;
    logic [agc_pkg::GainW-1:0] diff;

    always_comb
    begin
        if (sample > level_reg)
        begin
            diff       = sample - level_reg;
            level_next = level_reg + agc_pkg::div10(diff + 17'd9);
        end
        else
        begin
            diff       = level_reg - sample;
            level_next = level_reg - agc_pkg::div10(diff + 17'd9);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else if (en)
            level_reg <= level_next;
    end

    assign level = level_reg;

endmodule

@@ hw/rtl/agc_gain_mul.sv @@
// ----------------------------------------------------------------------------
// agc_gain_mul
// Product of two Q.16 gains, rounded half up.
// ----------------------------------------------------------------------------
module agc_gain_mul
(
    input  logic [agc_pkg::GainW-1:0] a,
    input  logic [agc_pkg::GainW-1:0] b,
    output logic [agc_pkg::GainW-1:0] y
);

    logic [33:0] prod;
    logic [33:0] sum;

    assign prod = {17'd0, a} * {17'd0, b};
    assign sum  = prod + {17'd0, agc_pkg::Half};
    assign y    = sum[32:16];

endmodule

@@ tb/sv/audio_ducking_gain_controller_tb.sv @@
// ----------------------------------------------------------------------------
// audio_ducking_gain_controller_tb
// Self-checking testbench of the ducking gain controller. Input beats come
// from a directed table and then from random ticks, mostly structured runs of
// soundbyte, button and track-end activity. A local model of the controller
// predicts every output beat, which is compared field by field in order.
// ----------------------------------------------------------------------------
module audio_ducking_gain_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [16:0] gain_t;

    typedef struct packed {
        logic [3:0]  buttons;
        logic        track_end;
        logic        playing;
        logic [1:0]  src;
        gain_t       pot6;
        gain_t       pot5;
        gain_t       pot4;
        gain_t       pot3;
        gain_t       pot2;
        gain_t       pot1;
        gain_t       pot0;
    } tick_t;

    typedef struct packed {
        logic [1:0]  phase;
        logic        trig;
        logic [7:0]  pos;
        logic [1:0]  saved;
        logic [1:0]  mode;
        logic [1:0]  src;
        gain_t       sb_vol;
        gain_t       pl_vol;
        gain_t       bt_vol;
        gain_t       lt_vol;
    } gains_t;

    typedef struct {
        tick_t  t;
        logic   fixed;
        gains_t g;
    } row_t;

    localparam int StallMax = 6;
    localparam int WatchLimit = 20000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [16:0]  cfg_data;

    audio_ducking_gain_controller dut (.*);

    // Predictor state.
    logic [63:0] lvl [agc_pkg::NumPots];
    logic [1:0]  m_phase;
    logic [63:0] m_duck, m_pause, m_xfade;
    logic        m_paused;
    logic [3:0]  m_hist;
    logic [1:0]  m_mode, m_saved, m_src;
    logic [63:0] m_pos;
    logic [63:0] r_slow, r_fast, r_len;

    gains_t expected_gains [$];
    int     errors;
    bit     stim_done;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    task automatic reset_model();
        for (int i = 0; i < agc_pkg::NumPots; i++)
            lvl[i] = 0;
        m_phase = agc_pkg::PH_IDLE;
        m_duck = 65536;
        m_pause = 65536;
        m_xfade = 0;
        m_paused = 0;
        m_hist = 0;
        m_mode = agc_pkg::MODE_NONE;
        m_saved = agc_pkg::MODE_NONE;
        m_src = 0;
        m_pos = 0;
        r_slow = 66;
        r_fast = 655;
        r_len = 0;
    endtask

    function automatic gains_t predict_gains(tick_t t);
        logic [63:0] pots [agc_pkg::NumPots];
        logic [63:0] s, stp, tgt, flr, bg, sf, cfs, len;
        logic [1:0]  src, nxt;
        logic [3:0]  rise;
        logic        trig;
        gains_t      g;
        pots = '{64'(t.pot0), 64'(t.pot1), 64'(t.pot2), 64'(t.pot3),
                 64'(t.pot4), 64'(t.pot5), 64'(t.pot6)};
        trig = 0;
        for (int i = 0; i < agc_pkg::NumPots; i++)
        begin
            s = (pots[i] > 65536) ? 64'd65536 : pots[i];
            if (s > lvl[i])
                lvl[i] = lvl[i] + (s - lvl[i] + 9) / 10;
            else
                lvl[i] = lvl[i] - (lvl[i] - s + 9) / 10;
        end
        src = (t.src == 2'd3) ? 2'd0 : t.src;
        rise = t.buttons & ~m_hist;
        m_hist = t.buttons;
        if (t.track_end)
        begin
            if (m_mode == agc_pkg::MODE_TABATA)
                m_mode = m_saved;
            else
            begin
                len = (r_len > 256) ? 64'd256 : r_len;
                if (len != 0)
                begin
                    m_pos = (m_pos + 1) % len;
                    trig = 1;
                end
            end
        end
        if (rise[0])
            m_paused ^= 1'b1;
        stp = (lvl[2] + 5) / 10;
        tgt = m_paused ? lvl[5] : 64'd65536;
        if (m_pause > tgt)
            m_pause = (m_pause - tgt > stp) ? m_pause - stp : tgt;
        else if (m_pause < tgt)
            m_pause = (tgt - m_pause > stp) ? m_pause + stp : tgt;
        for (int b = 1; b <= 3; b++)
            if (rise[b])
            begin
                nxt = (m_mode == b[1:0]) ? agc_pkg::MODE_NONE : b[1:0];
                if (nxt == agc_pkg::MODE_TABATA)
                    m_saved = m_mode;
                m_mode = nxt;
            end
        if (src != m_src && m_src != 0 && m_mode != agc_pkg::MODE_NONE)
            m_mode = agc_pkg::MODE_NONE;
        m_src = src;
        cfs = (m_mode == agc_pkg::MODE_CHILL) ? r_slow : r_fast;
        if (m_mode != agc_pkg::MODE_NONE)
        begin
            m_xfade += cfs;
            if (m_xfade > 65536)
                m_xfade = 65536;
        end
        else
            m_xfade = (m_xfade > cfs) ? m_xfade - cfs : 64'd0;
        flr = 3277 + qmul(65536 - 3277, lvl[3]);
        case (m_phase)
            agc_pkg::PH_IDLE:
                if (t.playing)
                    m_phase = agc_pkg::PH_DOWN;
            agc_pkg::PH_DOWN:
                if (m_duck <= flr + stp)
                begin
                    m_duck = flr;
                    m_phase = agc_pkg::PH_HELD;
                end
                else
                    m_duck -= stp;
            agc_pkg::PH_HELD:
            begin
                m_duck = flr;
                if (!t.playing)
                    m_phase = agc_pkg::PH_UP;
            end
            default:
                if (t.playing)
                    m_phase = agc_pkg::PH_DOWN;
                else
                begin
                    m_duck += stp;
                    if (m_duck >= 65536)
                    begin
                        m_duck = 65536;
                        m_phase = agc_pkg::PH_IDLE;
                    end
                end
        endcase
        bg = m_paused ? m_pause : m_duck;
        sf = 65536 - m_xfade;
        g.lt_vol = (m_src == 2'd1) ? gain_t'(qmul(qmul(lvl[0], bg), sf)) : '0;
        g.bt_vol = (m_src == 2'd2) ? gain_t'(qmul(qmul(lvl[1], bg), sf)) : '0;
        g.pl_vol = gain_t'(qmul(qmul(lvl[6], m_xfade), m_duck));
        g.sb_vol = t.playing ? gain_t'(lvl[4]) : '0;
        g.src = m_src;
        g.mode = m_mode;
        g.saved = m_saved;
        g.pos = m_pos[7:0];
        g.trig = trig;
        g.phase = m_phase;
        return g;
    endfunction

    // Valid stays high into the next beat when no gap is drawn.
    task automatic send_tick(tick_t t, logic fixed, gains_t g);
        gains_t p;
        int     gap;
        gap = $urandom_range(0, StallMax);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, t};
        do
            @(posedge clk);
        while (!s_axis_tready);
        p = predict_gains(t);
        if (fixed && p !== g)
        begin
            $error("directed row disagrees with predictor: %h vs %h", g, p);
            errors++;
        end
        expected_gains.push_back(p);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_gains.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            agc_pkg::CFG_STEP_SLOW: r_slow = 64'(val);
            agc_pkg::CFG_STEP_FAST: r_fast = 64'(val);
            default:                r_len = 64'(val[8:0]);
        endcase
    endtask

    function automatic gain_t rand_pot();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return gain_t'($urandom_range(65537, 131071));
            default: return gain_t'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic tick_t rand_tick(logic playing, logic [3:0] btn,
                                        logic tend, logic [1:0] src);
        tick_t t;
        t.pot0 = rand_pot();
        t.pot1 = rand_pot();
        t.pot2 = ($urandom_range(0, 3) == 0) ? rand_pot()
                                              : gain_t'($urandom_range(20000, 65536));
        t.pot3 = rand_pot();
        t.pot4 = rand_pot();
        t.pot5 = rand_pot();
        t.pot6 = rand_pot();
        t.src = src;
        t.playing = playing;
        t.track_end = tend;
        t.buttons = btn;
        return t;
    endfunction

    // Output side: random stalls and in-order comparison.
    always @(posedge clk)
    begin
        gains_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = gains_t'(m_axis_tdata[84:0]);
            if (expected_gains.size() == 0)
            begin
                $error("output beat with nothing expected: %h", got);
                errors++;
            end
            else
            begin
                want = expected_gains.pop_front();
                if (got.lt_vol !== want.lt_vol)
                    $error("laptop_volume expected %0d got %0d", want.lt_vol, got.lt_vol);
                if (got.bt_vol !== want.bt_vol)
                    $error("bluetooth_volume expected %0d got %0d", want.bt_vol, got.bt_vol);
                if (got.pl_vol !== want.pl_vol)
                    $error("playlist_volume expected %0d got %0d", want.pl_vol, got.pl_vol);
                if (got.sb_vol !== want.sb_vol)
                    $error("soundboard_volume expected %0d got %0d", want.sb_vol, got.sb_vol);
                if (got.src !== want.src)
                    $error("current_source expected %0d got %0d", want.src, got.src);
                if (got.mode !== want.mode)
                    $error("override_mode expected %0d got %0d", want.mode, got.mode);
                if (got.saved !== want.saved)
                    $error("saved_override expected %0d got %0d", want.saved, got.saved);
                if (got.pos !== want.pos)
                    $error("playlist_index expected %0d got %0d", want.pos, got.pos);
                if (got.trig !== want.trig)
                    $error("track_trigger expected %0d got %0d", want.trig, got.trig);
                if (got.phase !== want.phase)
                    $error("duck_phase expected %0d got %0d", want.phase, got.phase);
                if (got !== want)
                    errors++;
            end
        end
    end

    // The receiver holds each level for a random number of cycles.
    initial
    begin
        int hold;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, StallMax);
                m_axis_tready <= ~m_axis_tready | ($urandom_range(0, 2) == 0);
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || stim_done)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WatchLimit)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        row_t        rows [$];
        row_t        r;
        gains_t      g0;
        tick_t       t;
        logic        playing;
        logic [3:0]  btn;
        logic [1:0]  src;
        int          run;
        errors = 0;
        stim_done = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = agc_pkg::CFG_STEP_SLOW;
        cfg_data = '0;
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All zero after reset: every gain zero, everything idle.
        g0 = '0;
        r.t = '0; r.fixed = 1; r.g = g0; rows.push_back(r);
        // Soundbyte starts: duck goes to fading down; soundboard level still zero.
        r.t = '0; r.t.playing = 1; r.fixed = 1; r.g = g0; r.g.phase = agc_pkg::PH_DOWN;
        rows.push_back(r);
        // Pots above one, laptop source, pause press.
        r.t = '{buttons: 4'b0001, track_end: 0, playing: 1, src: 2'd1,
                default: 17'h1FFFF};
        r.fixed = 0; rows.push_back(r);
        r.t.buttons = 4'b0011; rows.push_back(r);
        r.t.buttons = 4'b0111; r.t.src = 2'd2; rows.push_back(r);
        r.t.buttons = 4'b0000; r.t.track_end = 1; rows.push_back(r);
        r.t.buttons = 4'b1000; r.t.src = 2'd3; rows.push_back(r);
        r.t.buttons = 4'b0100; r.t.track_end = 0; r.t.playing = 0; rows.push_back(r);
        r.t.buttons = 4'b0000; r.t.track_end = 1; rows.push_back(r);
        r.t = '{buttons: 4'b0010, track_end: 1, playing: 0, src: 2'd1,
                default: 17'd65536};
        rows.push_back(r);
        r.t.buttons = 4'b0001; rows.push_back(r);
        r.t.buttons = 4'b0000; r.t.src = 2'd2; rows.push_back(r);
        for (int i = 0; i < rows.size(); i++)
            send_tick(rows[i].t, rows[i].fixed, rows[i].g);
        drain();

        // Random phases over register settings, extremes included.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(agc_pkg::CFG_STEP_SLOW, 17'd1);
                         write_reg(agc_pkg::CFG_STEP_FAST, 17'd65536);
                         write_reg(agc_pkg::CFG_PL_LEN, 17'd3); end
                1: begin write_reg(agc_pkg::CFG_STEP_SLOW, 17'd65536);
                         write_reg(agc_pkg::CFG_STEP_FAST, 17'd1);
                         write_reg(agc_pkg::CFG_PL_LEN, 17'd256); end
                2: begin write_reg(agc_pkg::CFG_STEP_SLOW, 17'd0);
                         write_reg(agc_pkg::CFG_STEP_FAST, 17'h1FFFF);
                         write_reg(agc_pkg::CFG_PL_LEN, 17'd511); end
                3: begin write_reg(agc_pkg::CFG_STEP_SLOW, 17'($urandom_range(1, 65536)));
                         write_reg(agc_pkg::CFG_STEP_FAST, 17'($urandom_range(1, 65536)));
                         write_reg(agc_pkg::CFG_PL_LEN, 17'd1); end
                default: begin write_reg(agc_pkg::CFG_STEP_SLOW, 17'd66);
                         write_reg(agc_pkg::CFG_STEP_FAST, 17'd655);
                         write_reg(agc_pkg::CFG_PL_LEN, 17'd0); end
            endcase
            playing = 0;
            btn = 0;
            src = 2'd1;
            run = 0;
            for (int n = 0; n < 200; n++)
            begin
                if (run == 0)
                begin
                    // Hold the soundbyte for a run of random length; longer runs reach the floor and back.
                    run = $urandom_range(1, 40);
                    playing = $urandom_range(0, 1);
                end
                run--;
                btn = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'b0000;
                if ($urandom_range(0, 15) == 0)
                    src = 2'($urandom_range(0, 3));
                t = rand_tick(playing, btn, ($urandom_range(0, 7) == 0), src);
                send_tick(t, 0, g0);
                if (n == 100)
                    drain();
            end
            drain();
        end

        stim_done = 1;
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/agc_pkg.sv
hw/rtl/agc_lane.sv
hw/rtl/agc_gain_mul.sv
hw/rtl/audio_ducking_gain_controller.sv
tb/sv/audio_ducking_gain_controller_tb.sv
